FILE: sv/rab_pkg.sv
// ----------------------------------------------------------------------------
// rab_pkg: shared types and constants for the RGB565 alpha blitter
// Register indexes, field widths, geometry bundle and queue entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package rab_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int COORD_W    = 11;
	localparam int STRIDE_W   = 12;
	localparam int ADDR_W     = 24;
	localparam int COLOR_W    = 16;
	localparam int ALPHA_W    = 8;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X       = 3'd0,
		CFG_ORIGIN_Y       = 3'd1,
		CFG_IMAGE_WIDTH    = 3'd2,
		CFG_IMAGE_HEIGHT   = 3'd3,
		CFG_SURFACE_WIDTH  = 3'd4,
		CFG_SURFACE_HEIGHT = 3'd5,
		CFG_ROW_STRIDE     = 3'd6
	} cfg_index_t;

	// placement and clipping registers seen by the front end
	typedef struct packed {
		logic [15:0]        origin_x;
		logic [15:0]        origin_y;
		logic [COORD_W-1:0] image_width;
		logic [COORD_W-1:0] image_height;
		logic [COORD_W-1:0] surface_width;
		logic [COORD_W-1:0] surface_height;
	} geom_t;

	// one classified pixel request waiting for the back end
	typedef struct packed {
		logic               write_en;
		logic               last;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [COLOR_W-1:0] src;
		logic [ALPHA_W-1:0] alpha;
		logic [COLOR_W-1:0] dst;
	} item_t;

endpackage

`default_nettype wire

FILE: sv/rgb565_alpha_blit.sv
// ----------------------------------------------------------------------------
// rgb565_alpha_blit: per-pixel alpha blit into an RGB565 framebuffer
// Clips, blends and addresses one source pixel per request.
// ----------------------------------------------------------------------------
// Usage:
//   Source pixels enter in raster order on in_valid/in_stall together with the
//   framebuffer word at their target. Each request yields one result on
//   out_valid/out_stall: write flag, word address, blended color, last mark.
//   Throughput is one pixel per clock while out_stall is low; the front end,
//   the request queue and the two-stage blend pipeline each pass one request
//   per cycle. A request passes the queue slot, the blend products stage and
//   the output register on its way from input accept to output valid.
//   When the receiver stalls, the output register holds, the pipeline freezes
//   and requests collect in the queue; in_stall rises once the QUEUE_DEPTH
//   entries are full.
//   Registers are written on cfg_we with cfg_index/cfg_data while the block is
//   idle; any valid write restarts the raster position at the image origin.
//   Reset clears the configuration registers, the raster counters and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_alpha_blit #(
	parameter int MAX_DIMENSION = 2048,
	parameter int QUEUE_DEPTH   = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rab_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rab_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [rab_pkg::COLOR_W-1:0]    source_color,
	input  wire logic [rab_pkg::ALPHA_W-1:0]    source_alpha,
	input  wire logic [rab_pkg::COLOR_W-1:0]    dest_color,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                write_enable,
	output logic [rab_pkg::ADDR_W-1:0]          word_address,
	output logic [rab_pkg::COLOR_W-1:0]         blended_color,
	output logic                                last_pixel
);

	rab_pkg::geom_t               geom_q;
	logic [rab_pkg::STRIDE_W-1:0] row_stride_q;
	logic                         cfg_hit;
	logic                         push, full, head_valid, pop;
	rab_pkg::item_t               push_item, head;

	// decode a known register index
	always_comb begin
		case (cfg_index)
			rab_pkg::CFG_ORIGIN_X, rab_pkg::CFG_ORIGIN_Y, rab_pkg::CFG_IMAGE_WIDTH,
			rab_pkg::CFG_IMAGE_HEIGHT, rab_pkg::CFG_SURFACE_WIDTH,
			rab_pkg::CFG_SURFACE_HEIGHT, rab_pkg::CFG_ROW_STRIDE: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q       <= '0;
			row_stride_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rab_pkg::CFG_ORIGIN_X:       geom_q.origin_x       <= cfg_data;
				rab_pkg::CFG_ORIGIN_Y:       geom_q.origin_y       <= cfg_data;
				rab_pkg::CFG_IMAGE_WIDTH:    geom_q.image_width    <= cfg_data[10:0];
				rab_pkg::CFG_IMAGE_HEIGHT:   geom_q.image_height   <= cfg_data[10:0];
				rab_pkg::CFG_SURFACE_WIDTH:  geom_q.surface_width  <= cfg_data[10:0];
				rab_pkg::CFG_SURFACE_HEIGHT: geom_q.surface_height <= cfg_data[10:0];
				rab_pkg::CFG_ROW_STRIDE:     row_stride_q          <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	rab_front #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.geom         (geom_q),
		.clear        (cfg_hit),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.source_color (source_color),
		.source_alpha (source_alpha),
		.dest_color   (dest_color),
		.push         (push),
		.push_item    (push_item),
		.full         (full)
	);

	rab_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.head_valid (head_valid),
		.pop        (pop),
		.head       (head)
	);

	rab_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.row_stride    (row_stride_q),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.write_enable  (write_enable),
		.word_address  (word_address),
		.blended_color (blended_color),
		.last_pixel    (last_pixel)
	);

	// dropped pixels carry zero address and color
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> (word_address == '0) && (blended_color == '0))
		else $error("dropped pixel with nonzero fields");

	// queue only fills after an accepted request
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !$past(in_stall) |-> $past(in_valid))
		else $error("input stall without a request");

	// a fresh result traces back through the output register and stage 1 to a queued request
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(head_valid, 2))
		else $error("result without a queued request");

endmodule

`default_nettype wire

FILE: sv/rab_front.sv
// ----------------------------------------------------------------------------
// rab_front: pixel intake and classification
// Tracks the raster position, clips against the surface and queues requests.
// ----------------------------------------------------------------------------
`default_nettype none

module rab_front #(
	parameter int MAX_DIMENSION = 2048
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rab_pkg::geom_t              geom,
	input  wire logic                        clear,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [rab_pkg::COLOR_W-1:0] source_color,
	input  wire logic [rab_pkg::ALPHA_W-1:0] source_alpha,
	input  wire logic [rab_pkg::COLOR_W-1:0] dest_color,
	output logic                             push,
	output rab_pkg::item_t                   push_item,
	input  wire logic                        full
);

	localparam int CNT_W = $clog2(MAX_DIMENSION);
	localparam int CMP_W = ((CNT_W > rab_pkg::COORD_W) ? CNT_W : rab_pkg::COORD_W) + 1;
	localparam int POS_W = 18;

	logic [CNT_W-1:0] col_q, row_q;
	logic [CMP_W-1:0] col_nx, row_nx;
	logic             row_end, col_end, accept, on_surface;
	logic [POS_W-1:0] dx, dy;

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign push     = accept;

	// end of row / end of image tests
	assign col_nx  = CMP_W'(col_q) + CMP_W'(1);
	assign row_nx  = CMP_W'(row_q) + CMP_W'(1);
	assign row_end = (col_nx >= CMP_W'(geom.image_width)) ||
		(col_nx >= CMP_W'(MAX_DIMENSION));
	assign col_end = (row_nx >= CMP_W'(geom.image_height)) ||
		(row_nx >= CMP_W'(MAX_DIMENSION));

	// target position, clip against the surface
	assign dx = {{(POS_W-16){geom.origin_x[15]}}, geom.origin_x} + POS_W'(col_q);
	assign dy = {{(POS_W-16){geom.origin_y[15]}}, geom.origin_y} + POS_W'(row_q);
	assign on_surface = !dx[POS_W-1] && !dy[POS_W-1] &&
		(dx < POS_W'(geom.surface_width)) && (dy < POS_W'(geom.surface_height));

	// build the queued request
	always_comb begin
		push_item.write_en = on_surface && (source_alpha != '0);
		push_item.last     = row_end && col_end;
		push_item.col      = dx[rab_pkg::COORD_W-1:0];
		push_item.row      = dy[rab_pkg::COORD_W-1:0];
		push_item.src      = source_color;
		push_item.alpha    = source_alpha;
		push_item.dst      = dest_color;
	end

	// advance the raster counters, restart on any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= col_end ? '0 : row_nx[CNT_W-1:0];
			end else begin
				col_q <= col_nx[CNT_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/rab_fifo.sv
// ----------------------------------------------------------------------------
// rab_fifo: short request queue between front and back end
// Register-based FIFO of classified pixel requests.
// ----------------------------------------------------------------------------
`default_nettype none

module rab_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire rab_pkg::item_t push_item,
	output logic                full,
	output logic                head_valid,
	input  wire logic           pop,
	output rab_pkg::item_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rab_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// store incoming requests
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/rab_back.sv
// ----------------------------------------------------------------------------
// rab_back: blend and address pipeline
// Two stages: products and sums, then divide by 255, pack and address add.
// ----------------------------------------------------------------------------
`default_nettype none

module rab_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [rab_pkg::STRIDE_W-1:0] row_stride,
	input  wire logic                         head_valid,
	input  wire rab_pkg::item_t               head,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              write_enable,
	output logic [rab_pkg::ADDR_W-1:0]        word_address,
	output logic [rab_pkg::COLOR_W-1:0]       blended_color,
	output logic                              last_pixel
);

	localparam int SUM_W  = 14;
	localparam int PROD_W = rab_pkg::COORD_W + rab_pkg::STRIDE_W;

	// s*a + d*(255-a) + 127 on one channel
	function automatic logic [SUM_W-1:0] mix_sum(input logic [5:0] s, input logic [5:0] d,
			input logic [7:0] a);
		logic [7:0]       inv;
		logic [SUM_W-1:0] ps, pd;
		inv = 8'd255 - a;
		ps  = {8'b0, s} * {6'b0, a};
		pd  = {8'b0, d} * {6'b0, inv};
		return ps + pd + SUM_W'(127);
	endfunction

	// exact x/255 for x below 16320
	function automatic logic [5:0] div255(input logic [SUM_W-1:0] x);
		logic [15:0] t;
		t = 16'(x) + 16'd1 + {10'b0, x[SUM_W-1:8]};
		return t[13:8];
	endfunction

	logic                      en;
	logic                      valid_s1, we_s1, last_s1;
	logic [PROD_W-1:0]         prod_s1;
	logic [rab_pkg::COORD_W-1:0] col_s1;
	logic [SUM_W-1:0]          sum_r_s1, sum_g_s1, sum_b_s1;
	logic [5:0]                q_r, q_g, q_b;

	// pipeline moves whenever the output slot is free or being taken
	assign en  = !out_valid || !out_stall;
	assign pop = en && head_valid;

	// stage 1 valid and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= head_valid;
		end
	end

	// stage 1 payload: channel sums and row offset
	always_ff @(posedge clk) begin
		if (en) begin
			we_s1    <= head.write_en;
			last_s1  <= head.last;
			col_s1   <= head.col;
			prod_s1  <= {{rab_pkg::STRIDE_W{1'b0}}, head.row} *
				{{rab_pkg::COORD_W{1'b0}}, row_stride};
			sum_r_s1 <= mix_sum({1'b0, head.src[15:11]}, {1'b0, head.dst[15:11]}, head.alpha);
			sum_g_s1 <= mix_sum(head.src[10:5], head.dst[10:5], head.alpha);
			sum_b_s1 <= mix_sum({1'b0, head.src[4:0]}, {1'b0, head.dst[4:0]}, head.alpha);
		end
	end

	assign q_r = div255(sum_r_s1);
	assign q_g = div255(sum_g_s1);
	assign q_b = div255(sum_b_s1);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s1;
		end
	end

	// output register payload, zero fields on dropped pixels
	always_ff @(posedge clk) begin
		if (en) begin
			write_enable  <= we_s1;
			last_pixel    <= last_s1;
			word_address  <= we_s1 ? (rab_pkg::ADDR_W'(prod_s1) + rab_pkg::ADDR_W'(col_s1)) : '0;
			blended_color <= we_s1 ? {q_r[4:0], q_g, q_b[4:0]} : '0;
		end
	end

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RGB565 alpha blitter
// Streams source pixels through the block under several placements, image
// sizes, clip windows and strides. A predictor tracks the raster
// counters, computes clipping, address and the per-channel blend, and checks
// every result in order while both handshake sides idle and stall at random in most phases.
// ----------------------------------------------------------------------------

module testbench;

	import rab_pkg::*;

	localparam int MAX_DIM        = 2048;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;

	// register index that decodes to nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [ALPHA_W-1:0] alpha;
		logic [COLOR_W-1:0] dst;
	} pixel_req_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [COLOR_W-1:0] color;
		logic              last;
	} blit_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic [COLOR_W-1:0]    source_color = '0;
	logic [ALPHA_W-1:0]    source_alpha = '0;
	logic [COLOR_W-1:0]    dest_color   = '0;
	logic                  out_stall    = 1'b0;

	logic               in_stall;
	logic               out_valid;
	logic               write_enable;
	logic [ADDR_W-1:0]  word_address;
	logic [COLOR_W-1:0] blended_color;
	logic               last_pixel;

	// predictor copy of the registers and raster counters
	logic [15:0]         g_origin_x = '0;
	logic [15:0]         g_origin_y = '0;
	logic [COORD_W-1:0]  g_img_w    = '0;
	logic [COORD_W-1:0]  g_img_h    = '0;
	logic [COORD_W-1:0]  g_surf_w   = '0;
	logic [COORD_W-1:0]  g_surf_h   = '0;
	logic [STRIDE_W-1:0] g_stride   = '0;
	logic [COORD_W-1:0]  g_col      = '0;
	logic [COORD_W-1:0]  g_row      = '0;

	pixel_req_t   pixel_requests[$];
	blit_result_t predicted_pixels[$];
	pixel_req_t   next_req;
	blit_result_t seen, want;

	logic req_taken = 1'b0;
	int   send_idle_pct = 23;
	int   recv_idle_pct = 50;
	int   idle_cycles = 0;
	int   mismatch_count = 0;
	int   pixels_sent = 0;
	int   writes_seen = 0;
	int   lasts_seen = 0;
	int   settings_written = 0;

	rgb565_alpha_blit #(
		.MAX_DIMENSION(MAX_DIM)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.source_color (source_color),
		.source_alpha (source_alpha),
		.dest_color   (dest_color),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.write_enable (write_enable),
		.word_address (word_address),
		.blended_color(blended_color),
		.last_pixel   (last_pixel)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// blend one channel with rounding
	function automatic int mix_channel(input int s, input int d, input int a);
		return (s * a + d * (255 - a) + 127) / 255;
	endfunction

	// counter is at the last position of its dimension
	function automatic logic raster_end(input logic [COORD_W-1:0] cnt,
			input logic [COORD_W-1:0] size);
		return (int'(cnt) + 1 >= int'(size)) || (int'(cnt) + 1 >= MAX_DIM);
	endfunction

	// clip, address and blend the pixel at the current raster position
	function automatic blit_result_t blend_and_place(input pixel_req_t req);
		blit_result_t res;
		int dx, dy, r, g, b;
		logic [31:0] lin;
		logic visible;
		dx = int'($signed(g_origin_x)) + int'(g_col);
		dy = int'($signed(g_origin_y)) + int'(g_row);
		visible = dx >= 0 && dy >= 0 && dx < int'(g_surf_w) && dy < int'(g_surf_h);
		res = '0;
		res.we = visible && req.alpha != 0;
		if (res.we) begin
			lin = dy * int'(g_stride) + dx;
			res.addr = lin[ADDR_W-1:0];
			r = mix_channel(int'(req.color[15:11]), int'(req.dst[15:11]), int'(req.alpha));
			g = mix_channel(int'(req.color[10:5]), int'(req.dst[10:5]), int'(req.alpha));
			b = mix_channel(int'(req.color[4:0]), int'(req.dst[4:0]), int'(req.alpha));
			res.color = {r[4:0], g[5:0], b[4:0]};
		end
		res.last = raster_end(g_col, g_img_w) && raster_end(g_row, g_img_h);
		return res;
	endfunction

	// step the raster counters past one pixel
	task automatic advance_raster();
		if (raster_end(g_col, g_img_w)) begin
			g_col = '0;
			g_row = raster_end(g_row, g_img_h) ? '0 : g_row + 1'b1;
		end else begin
			g_col = g_col + 1'b1;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// write one register on an idle block and mirror it in the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		logic known;
		known = 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_ORIGIN_X:       g_origin_x = data;
			CFG_ORIGIN_Y:       g_origin_y = data;
			CFG_IMAGE_WIDTH:    g_img_w    = data[COORD_W-1:0];
			CFG_IMAGE_HEIGHT:   g_img_h    = data[COORD_W-1:0];
			CFG_SURFACE_WIDTH:  g_surf_w   = data[COORD_W-1:0];
			CFG_SURFACE_HEIGHT: g_surf_h   = data[COORD_W-1:0];
			CFG_ROW_STRIDE:     g_stride   = data[STRIDE_W-1:0];
			default:            known      = 1'b0;
		endcase
		if (known) begin
			g_col = '0;
			g_row = '0;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_written++;
	endtask

	// hold until no request is queued, driven or in flight
	task automatic wait_idle();
		do @(posedge clk);
		while (pixel_requests.size() != 0 || in_valid || predicted_pixels.size() != 0);
	endtask

	// drain, then load a full geometry; junk above the field width is dropped
	task automatic set_geometry(input logic [15:0] ox, input logic [15:0] oy,
			input logic [COORD_W-1:0] iw, input logic [COORD_W-1:0] ih,
			input logic [COORD_W-1:0] sw, input logic [COORD_W-1:0] sh,
			input logic [STRIDE_W-1:0] st);
		logic [15:0] junk;
		junk = 16'($urandom);
		wait_idle();
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_IMAGE_WIDTH, {junk[15:11], iw});
		write_reg(CFG_IMAGE_HEIGHT, {junk[14:10], ih});
		write_reg(CFG_SURFACE_WIDTH, {junk[13:9], sw});
		write_reg(CFG_SURFACE_HEIGHT, {junk[12:8], sh});
		write_reg(CFG_ROW_STRIDE, {junk[11:8], st});
	endtask

	task automatic queue_pixel(input logic [15:0] color, input logic [7:0] alpha,
			input logic [15:0] dst);
		pixel_requests.push_back('{color: color, alpha: alpha, dst: dst});
	endtask

	// random pixels with alpha biased toward transparent and opaque
	task automatic queue_random(input int n);
		int sel;
		logic [7:0] a;
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(0, 5);
			a = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(0, 255));
			queue_pixel(16'($urandom_range(0, 65535)), a, 16'($urandom_range(0, 65535)));
		end
	endtask

	// placement offset: mostly near the surface, sometimes anywhere
	function automatic logic [15:0] pick_offset();
		logic [15:0] v;
		if ($urandom_range(0, 7) == 0) begin
			v = 16'($urandom);
		end else begin
			v = 16'($urandom_range(0, 16));
			v = v - 16'd6;
		end
		return v;
	endfunction

	// reset once at the start
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// advance the request when the last one was taken or none is up
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			if (pixel_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_req = pixel_requests.pop_front();
				in_valid     <= 1'b1;
				source_color <= next_req.color;
				source_alpha <= next_req.alpha;
				dest_color   <= next_req.dst;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= $urandom_range(0, 99) < recv_idle_pct;
	end

	// predict each accepted request
	always @(posedge clk) begin
		req_taken = arst_n && in_valid && !in_stall;
		if (req_taken) begin
			predicted_pixels.push_back(blend_and_place('{color: source_color,
				alpha: source_alpha, dst: dest_color}));
			advance_raster();
			pixels_sent++;
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen = '{we: write_enable, addr: word_address, color: blended_color,
				last: last_pixel};
			if (predicted_pixels.size() == 0) begin
				report_mismatch($sformatf("result with nothing predicted: %p", seen));
			end else begin
				want = predicted_pixels.pop_front();
				if (seen.we != want.we)
					report_mismatch($sformatf("write_enable %0b, predicted %0b",
						seen.we, want.we));
				if (seen.addr != want.addr)
					report_mismatch($sformatf("word_address %0d, predicted %0d",
						seen.addr, want.addr));
				if (seen.color != want.color)
					report_mismatch($sformatf("blended_color %h, predicted %h",
						seen.color, want.color));
				if (seen.last != want.last)
					report_mismatch($sformatf("last_pixel %0b, predicted %0b",
						seen.last, want.last));
			end
			writes_seen += int'(seen.we);
			lasts_seen  += int'(seen.last);
		end
	end

	// count cycles without any progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// stimulus
	initial begin
		logic [15:0] ox, oy;
		logic [COORD_W-1:0] iw, ih, sw, sh;
		logic [STRIDE_W-1:0] st;
		int phase;

		wait (arst_n);

		// color and alpha extremes, right column clipped
		set_geometry(16'd0, 16'd0, 11'd4, 11'd2, 11'd3, 11'd2, 12'd5);
		queue_pixel(16'h0000, 8'd255, 16'hFFFF);
		queue_pixel(16'hFFFF, 8'd0,   16'h0000);
		queue_pixel(16'hFFFF, 8'd128, 16'h0000);
		queue_pixel(16'hFFFF, 8'd255, 16'hFFFF);
		queue_pixel(16'hF800, 8'd1,   16'h07E0);
		queue_pixel(16'h07E0, 8'd254, 16'h001F);
		queue_pixel(16'h001F, 8'd127, 16'hF800);
		queue_pixel(16'hAAAA, 8'd255, 16'h5555);

		// zero image size acts as one pixel; far corner of the largest surface
		set_geometry(16'd2046, 16'd2046, 11'd0, 11'd0, 11'd2047, 11'd2047, 12'd4095);
		queue_pixel(16'h1234, 8'd200, 16'hFEDC);
		queue_pixel(16'hFFFF, 8'd255, 16'h0000);

		// extreme origins land off the surface
		set_geometry(16'h8000, 16'h7FFF, 11'd2, 11'd1, 11'd2047, 11'd2047, 12'd4095);
		queue_pixel(16'hFFFF, 8'd255, 16'hFFFF);
		queue_pixel(16'h0000, 8'd255, 16'h0000);

		// negative origin with a one-pixel window and zero stride
		set_geometry(16'hFFFF, 16'hFFFF, 11'd2, 11'd2, 11'd1, 11'd1, 12'd0);
		queue_random(4);

		// a write to an unused index leaves the raster position alone
		set_geometry(16'd0, 16'd0, 11'd3, 11'd3, 11'd3, 11'd3, 12'd3);
		queue_random(2);
		wait_idle();
		write_reg(CFG_UNUSED_IDX, 16'($urandom));
		queue_random(7);

		// fixed and random geometries across the three idle schemes
		for (phase = 0; phase < 12; phase++) begin
			if (phase == 0) begin
				ox = 16'd0; oy = 16'd0; iw = 11'd2047; ih = 11'd2047;
				sw = 11'd2047; sh = 11'd2047; st = 12'd4095;
			end else if (phase == 1) begin
				ox = 16'd0; oy = 16'd0; iw = 11'd0; ih = 11'd0;
				sw = 11'd0; sh = 11'd0; st = 12'd0;
			end else begin
				ox = pick_offset();
				oy = pick_offset();
				iw = ($urandom_range(0, 9) == 0) ? 11'd2047 : 11'($urandom_range(0, 12));
				ih = 11'($urandom_range(0, 8));
				sw = ($urandom_range(0, 7) == 0) ? 11'd2047 : 11'($urandom_range(0, 16));
				sh = ($urandom_range(0, 7) == 0) ? 11'd2047 : 11'($urandom_range(0, 16));
				st = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095)) :
					12'($urandom_range(0, 20));
			end
			set_geometry(ox, oy, iw, ih, sw, sh, st);
			if (phase < 4) begin
				send_idle_pct = 23; recv_idle_pct = 50;
			end else if (phase < 8) begin
				send_idle_pct = 50; recv_idle_pct = 23;
			end else begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			queue_random($urandom_range(30, 60));
		end

		// let everything drain, then a few quiet cycles
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Blitted %0d pixels under %0d register writes", pixels_sent, settings_written);
		$display("Stored %0d pixels, saw %0d image ends", writes_seen, lasts_seen);
		if (mismatch_count == 0 && predicted_pixels.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
